### design/kruskal_union_find_mst_top_assert.svh
// Assertion macros for the union-find spanning tree block
`ifndef KRUSKAL_UNION_FIND_MST_TOP_ASSERT_SVH
`define KRUSKAL_UNION_FIND_MST_TOP_ASSERT_SVH

// Same-cycle implication, muted during reset
`define KUMST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kumst: same-cycle check failed");

// Next-cycle implication, muted during reset
`define KUMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kumst: next-cycle check failed");

`endif

### design/kumst_pkg.sv
// Package: widths, defaults and sequencer states of the spanning tree block
`timescale 1ns / 1ps
package kumst_pkg;
   localparam int NODE_FIELD_W    = 6;
   localparam int WEIGHT_FIELD_W  = 16;
   localparam int SUM_W           = 22;
   localparam int COUNT_W         = 7;
   localparam int DEF_MAX_NODES   = 64;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
   localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_FINISH
   } kumst_state_type;
endpackage

### design/kumst_req_if.sv
// Edge channel interface: valid, ready and one edge
`timescale 1ns / 1ps
interface kumst_req_if;
   import kumst_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [NODE_FIELD_W-1:0]   edge_from;
   logic [NODE_FIELD_W-1:0]   edge_to;
   logic [WEIGHT_FIELD_W-1:0] edge_weight;
   logic                      first_edge;
   logic                      last_edge;

   modport source (output valid, edge_from, edge_to, edge_weight, first_edge, last_edge,
                   input ready);
   modport sink   (input valid, edge_from, edge_to, edge_weight, first_edge, last_edge,
                   output ready);
endinterface

### design/kumst_rsp_if.sv
// Result channel interface: valid, ready and one edge verdict
`timescale 1ns / 1ps
interface kumst_rsp_if;
   import kumst_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      edge_taken;
   logic [NODE_FIELD_W-1:0]   taken_from;
   logic [NODE_FIELD_W-1:0]   taken_to;
   logic [WEIGHT_FIELD_W-1:0] taken_weight;
   logic [SUM_W-1:0]          weight_sum;
   logic                      edge_error;
   logic                      run_done;

   modport source (output valid, edge_taken, taken_from, taken_to, taken_weight,
                   weight_sum, edge_error, run_done,
                   input ready);
   modport sink   (input valid, edge_taken, taken_from, taken_to, taken_weight,
                   weight_sum, edge_error, run_done,
                   output ready);
endinterface

### design/kumst_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module kumst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/kruskal_union_find_mst_top.sv
// Kruskal spanning tree edge selector over a union-find parent table
// Usage:
//  req_if carries one edge per beat, sorted by ascending weight; first_edge
//  restarts the forest and clears the running total before the edge is used.
//  rsp_if returns one beat per edge: taken flag, echoes, running total,
//  range error and the last_edge echo. csr_wr_en/csr_wr_data set node_count.
//  An out-of-range edge goes from idle straight to the final step, which
//  loads its result into the output register. Otherwise the sequencer walks
//  parent links one per cycle through the parent RAM, from edge_from, then
//  from edge_to, at most MAX_NODES links each. The next edge is taken once the
//  sequencer returns to idle; one result waits in the output register.
//  Reset: node_count returns to 64, every node is its own root, total zero.
//  A stalled result receiver holds the finished result in the output
//  register; the sequencer then waits in its final step until the register
//  frees, and the edge channel stays not ready.
`timescale 1ns / 1ps
`include "kruskal_union_find_mst_top_assert.svh"
module kruskal_union_find_mst_top #(
   parameter int MAX_NODES   = kumst_pkg::DEF_MAX_NODES,
   parameter int WEIGHT_BITS = kumst_pkg::DEF_WEIGHT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   kumst_req_if.sink                    req_if,
   kumst_rsp_if.source                  rsp_if,
   input  logic                         csr_wr_en,
   input  logic [kumst_pkg::COUNT_W-1:0] csr_wr_data
);
   import kumst_pkg::*;

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int STEP_W = $clog2(MAX_NODES + 1);
   localparam int WUSE   = (WEIGHT_BITS < WEIGHT_FIELD_W) ? WEIGHT_BITS : WEIGHT_FIELD_W;
   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_NODES);

   kumst_state_type           state_ff, state_in;
   logic [COUNT_W-1:0]        node_count_ff;
   logic [MAX_NODES-1:0]      link_valid_ff, link_valid_in;
   logic [SUM_W-1:0]          total_ff, total_in;
   logic [NODE_FIELD_W-1:0]   from_ff, from_in;
   logic [NODE_FIELD_W-1:0]   to_ff, to_in;
   logic [WUSE-1:0]           weight_ff, weight_in;
   logic                      last_ff, last_in;
   logic                      err_ff, err_in;
   logic                      taken_ff, taken_in;
   logic [NODE_W-1:0]         cur_ff, cur_in;
   logic                      pend_ff, pend_in;
   logic [STEP_W-1:0]         steps_ff, steps_in;
   logic [NODE_W-1:0]         root_a_ff, root_a_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_taken_ff;
   logic [NODE_FIELD_W-1:0]   rsp_from_ff;
   logic [NODE_FIELD_W-1:0]   rsp_to_ff;
   logic [WEIGHT_FIELD_W-1:0] rsp_weight_ff;
   logic [SUM_W-1:0]          rsp_sum_ff;
   logic                      rsp_error_ff;
   logic                      rsp_done_ff;
   logic                      rsp_load;

   logic                      ram_we;
   logic [NODE_W-1:0]         ram_addr;
   logic [NODE_W-1:0]         ram_wdata;
   logic [NODE_W-1:0]         ram_rdata;

   logic [NODE_W-1:0]         walk_node;
   logic                      walk_more;
   logic                      out_free;
   logic                      req_error;
   logic [SUM_W:0]            sum_wide;

   kumst_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign walk_node = pend_ff ? ram_rdata : cur_ff;
   assign walk_more = link_valid_ff[walk_node] && (steps_ff < STEP_LIMIT);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign sum_wide  = {1'b0, total_ff} + (SUM_W + 1)'(weight_ff);
   assign req_error = (COUNT_W'(req_if.edge_from) >= node_count_ff)
                   || (COUNT_W'(req_if.edge_to) >= node_count_ff)
                   || (32'(req_if.edge_from) >= 32'(MAX_NODES))
                   || (32'(req_if.edge_to) >= 32'(MAX_NODES));

   always_comb begin
      state_in      = state_ff;
      link_valid_in = link_valid_ff;
      total_in      = total_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      weight_in     = weight_ff;
      last_in       = last_ff;
      err_in        = err_ff;
      taken_in      = taken_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      steps_in      = steps_ff;
      root_a_in     = root_a_ff;
      ram_we        = 1'b0;
      ram_addr      = walk_node;
      ram_wdata     = walk_node;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               from_in   = req_if.edge_from;
               to_in     = req_if.edge_to;
               weight_in = req_if.edge_weight[WUSE-1:0];
               last_in   = req_if.last_edge;
               err_in    = req_error;
               taken_in  = 1'b0;
               cur_in    = NODE_W'(req_if.edge_from);
               pend_in   = 1'b0;
               steps_in  = '0;
               if (req_if.first_edge) begin
                  link_valid_in = '0;
                  total_in      = '0;
               end
               state_in = req_error ? ST_FINISH : ST_WALK_A;
            end
         end
         ST_WALK_A: begin
            if (walk_more) begin
               cur_in   = walk_node;
               pend_in  = 1'b1;
               steps_in = steps_ff + STEP_W'(1);
            end else begin
               root_a_in = walk_node;
               cur_in    = NODE_W'(to_ff);
               pend_in   = 1'b0;
               steps_in  = '0;
               state_in  = ST_WALK_B;
            end
         end
         ST_WALK_B: begin
            if (walk_more) begin
               cur_in   = walk_node;
               pend_in  = 1'b1;
               steps_in = steps_ff + STEP_W'(1);
            end else begin
               pend_in = 1'b0;
               if (root_a_ff != walk_node) begin
                  ram_we                   = 1'b1;
                  ram_addr                 = root_a_ff;
                  ram_wdata                = walk_node;
                  link_valid_in[root_a_ff] = 1'b1;
                  taken_in                 = 1'b1;
                  total_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= COUNT_RESET;
         link_valid_ff <= '0;
         total_ff      <= '0;
         pend_ff       <= 1'b0;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         link_valid_ff <= link_valid_in;
         total_ff      <= total_in;
         pend_ff       <= pend_in;
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      from_ff   <= from_in;
      to_ff     <= to_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
      taken_ff  <= taken_in;
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
      if (rsp_load) begin
         rsp_taken_ff  <= taken_ff;
         rsp_from_ff   <= from_ff;
         rsp_to_ff     <= to_ff;
         rsp_weight_ff <= WEIGHT_FIELD_W'(weight_ff);
         rsp_sum_ff    <= total_ff;
         rsp_error_ff  <= err_ff;
         rsp_done_ff   <= last_ff;
      end
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.edge_taken   = rsp_taken_ff;
   assign rsp_if.taken_from   = rsp_from_ff;
   assign rsp_if.taken_to     = rsp_to_ff;
   assign rsp_if.taken_weight = rsp_weight_ff;
   assign rsp_if.weight_sum   = rsp_sum_ff;
   assign rsp_if.edge_error   = rsp_error_ff;
   assign rsp_if.run_done     = rsp_done_ff;

   `KUMST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, state_ff != ST_IDLE)
   `KUMST_ASSERT_IMPLIES(a_step_bound, clock, reset, 1'b1, steps_ff <= STEP_LIMIT)
   `KUMST_ASSERT_IMPLIES(a_link_in_walk, clock, reset, ram_we, state_ff == ST_WALK_B && !err_ff)
   `KUMST_ASSERT_IMPLIES(a_taken_no_error, clock, reset, rsp_if.valid && rsp_if.edge_taken, !rsp_if.edge_error)
endmodule

### tb/tb_kruskal_union_find_mst_top.sv
// Self-checking testbench for the union-find spanning tree edge selector
`timescale 1ns / 1ps
module tb_kruskal_union_find_mst_top;
   import kumst_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 600;
   localparam int END_DRAIN   = 140;

   typedef struct {
      logic [NODE_FIELD_W-1:0]   src;
      logic [NODE_FIELD_W-1:0]   dst;
      logic [WEIGHT_FIELD_W-1:0] weight;
      logic                      first;
      logic                      last;
   } edge_item_type;

   typedef struct {
      logic                      taken;
      logic [NODE_FIELD_W-1:0]   src;
      logic [NODE_FIELD_W-1:0]   dst;
      logic [WEIGHT_FIELD_W-1:0] weight;
      logic [SUM_W-1:0]          total;
      logic                      error;
      logic                      done;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [COUNT_W-1:0]   csr_wr_data;

   kumst_req_if req_ch ();
   kumst_rsp_if rsp_ch ();

   kruskal_union_find_mst_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   edge_item_type edge_backlog [$];
   verdict_type   expected_verdicts [$];

   logic [NODE_FIELD_W-1:0] forest_parent [DEF_MAX_NODES];
   logic [DEF_MAX_NODES-1:0] forest_linked;
   logic [SUM_W-1:0]        running_total;
   logic [COUNT_W-1:0]      node_limit;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   int holds_served;
   int hold_left;
   int quiet_cycles;
   int fail_count;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_forest();
      forest_linked = '0;
      running_total = '0;
   endfunction

   function automatic logic [NODE_FIELD_W-1:0] root_of(logic [NODE_FIELD_W-1:0] node);
      logic [NODE_FIELD_W-1:0] walk;
      int steps;
      walk = node;
      steps = 0;
      while (forest_linked[walk] && steps < DEF_MAX_NODES) begin
         walk = forest_parent[walk];
         steps++;
      end
      return walk;
   endfunction

   function automatic verdict_type judge_edge(edge_item_type beat);
      verdict_type v;
      logic [NODE_FIELD_W-1:0] root_a;
      logic [NODE_FIELD_W-1:0] root_b;
      logic [SUM_W:0] grown;
      if (beat.first) clear_forest();
      v.taken  = 1'b0;
      v.src    = beat.src;
      v.dst    = beat.dst;
      v.weight = beat.weight;
      v.done   = beat.last;
      v.error  = (beat.src >= node_limit) || (beat.dst >= node_limit);
      if (!v.error) begin
         root_a = root_of(beat.src);
         root_b = root_of(beat.dst);
         if (root_a != root_b) begin
            forest_parent[root_a] = root_b;
            forest_linked[root_a] = 1'b1;
            v.taken = 1'b1;
            grown = {1'b0, running_total} + (SUM_W + 1)'(beat.weight);
            running_total = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
         end
      end
      v.total = running_total;
      return v;
   endfunction

   // driver and predictor
   always @(posedge clock) begin
      edge_item_type cur;
      edge_item_type nxt;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.edge_from   <= '0;
         req_ch.edge_to     <= '0;
         req_ch.edge_weight <= '0;
         req_ch.first_edge  <= 1'b0;
         req_ch.last_edge   <= 1'b0;
         node_limit         <= COUNT_RESET;
         clear_forest();
      end else begin
         if (csr_wr_en) node_limit <= csr_wr_data;
         if (req_ch.valid && req_ch.ready) begin
            cur.src    = req_ch.edge_from;
            cur.dst    = req_ch.edge_to;
            cur.weight = req_ch.edge_weight;
            cur.first  = req_ch.first_edge;
            cur.last   = req_ch.last_edge;
            expected_verdicts.push_back(judge_edge(cur));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (edge_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = edge_backlog.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.edge_from   <= nxt.src;
               req_ch.edge_to     <= nxt.dst;
               req_ch.edge_weight <= nxt.weight;
               req_ch.first_edge  <= nxt.first;
               req_ch.last_edge   <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: random stalls plus requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         holds_served <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result beat expected none, got from %0d to %0d total %0d",
                     $time, rsp_ch.taken_from, rsp_ch.taken_to, rsp_ch.weight_sum);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("edge_taken",   want.taken,  rsp_ch.edge_taken);
            check_field("taken_from",   want.src,    rsp_ch.taken_from);
            check_field("taken_to",     want.dst,    rsp_ch.taken_to);
            check_field("taken_weight", want.weight, rsp_ch.taken_weight);
            check_field("weight_sum",   want.total,  rsp_ch.weight_sum);
            check_field("edge_error",   want.error,  rsp_ch.edge_error);
            check_field("run_done",     want.done,   rsp_ch.run_done);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void queue_edge(int src, int dst, int weight, bit first, bit last);
      edge_item_type beat;
      beat.src    = NODE_FIELD_W'(src);
      beat.dst    = NODE_FIELD_W'(dst);
      beat.weight = WEIGHT_FIELD_W'(weight);
      beat.first  = first;
      beat.last   = last;
      edge_backlog.push_back(beat);
   endfunction

   function automatic int queue_graph(int limit, bit well_formed, int room);
      int span;
      int n_edges;
      int weight;
      int step_cap;
      edge_item_type beat;
      span = (limit > DEF_MAX_NODES) ? DEF_MAX_NODES : limit;
      span = (span < 2) ? 2 : $urandom_range(span, 2);
      n_edges = $urandom_range(2 * span, 1);
      if (n_edges > room) n_edges = room;
      weight = $urandom_range(3000, 1);
      case ($urandom_range(2))
         0: step_cap = 3;
         1: step_cap = 300;
         default: step_cap = 4000;
      endcase
      for (int i = 0; i < n_edges; i++) begin
         beat.src    = NODE_FIELD_W'($urandom_range(span - 1));
         beat.dst    = NODE_FIELD_W'($urandom_range(span - 1));
         beat.weight = WEIGHT_FIELD_W'(weight);
         beat.first  = (i == 0);
         beat.last   = (i == n_edges - 1);
         if (!well_formed) begin
            if ($urandom_range(5) == 0) beat.src = NODE_FIELD_W'($urandom_range(63));
            if ($urandom_range(5) == 0) beat.dst = NODE_FIELD_W'($urandom_range(63));
            beat.weight = WEIGHT_FIELD_W'($urandom_range(65535));
            beat.first  = ($urandom_range(7) == 0);
            beat.last   = ($urandom_range(7) == 0);
         end
         edge_backlog.push_back(beat);
         weight = weight + $urandom_range(step_cap);
         if (weight > 65535) weight = 65535;
      end
      return n_edges;
   endfunction

   // chain 0->1->...->span-1, then two walks across its full depth
   function automatic int queue_chain(int span, int weight);
      for (int i = 0; i < span - 1; i++) queue_edge(i, i + 1, weight, i == 0, 1'b0);
      queue_edge(0, span - 1, weight, 1'b0, 1'b0);
      queue_edge(span - 1, 0, weight, 1'b0, 1'b1);
      return span + 1;
   endfunction

   function automatic void queue_phase(int limit, int target);
      int queued;
      int pick;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            queued += queue_graph(limit, 1'b1, target - queued);
         end else if (pick < 90) begin
            queued += queue_graph(limit, 1'b0, target - queued);
         end else begin
            queue_edge($urandom_range(63), $urandom_range(63), $urandom_range(65535),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            queued++;
         end
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (edge_backlog.size() != 0 || expected_verdicts.size() != 0 || req_ch.valid);
   endtask

   task automatic write_node_count(int value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
         default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
   endtask

   initial begin
      int counts [12];
      int queued;
      counts         = '{64, 17, 64, 2, 64, 40, 1, 64, 9, 127, 64, 33};
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.edge_from   = '0;
      req_ch.edge_to     = '0;
      req_ch.edge_weight = '0;
      req_ch.first_edge  = 1'b0;
      req_ch.last_edge   = 1'b0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = 0;
      quiet_cycles   = 0;
      fail_count     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_edge(0, 63, 1, 1'b1, 1'b0);
      queue_edge(63, 0, 2, 1'b0, 1'b0);
      queue_edge(5, 5, 3, 1'b0, 1'b0);
      queue_edge(0, 1, 0, 1'b0, 1'b0);
      queue_edge(62, 61, 65535, 1'b0, 1'b0);
      queue_edge(1, 62, 65535, 1'b0, 1'b1);
      write_node_count(2);
      queue_edge(0, 1, 65535, 1'b0, 1'b0);
      queue_edge(1, 2, 65535, 1'b0, 1'b1);
      write_node_count(0);
      queue_edge(0, 0, 10, 1'b1, 1'b0);
      queue_edge(42, 21, 20, 1'b0, 1'b1);
      write_node_count(1);
      queue_edge(0, 0, 5, 1'b1, 1'b0);
      queue_edge(0, 1, 6, 1'b0, 1'b0);
      queue_edge(63, 0, 7, 1'b0, 1'b1);
      write_node_count(127);
      queue_edge(63, 62, 100, 1'b1, 1'b0);
      queue_edge(62, 63, 200, 1'b0, 1'b0);
      queue_edge(0, 42, 65535, 1'b0, 1'b1);
      write_node_count(2);
      queue_edge(1, 0, 7, 1'b1, 1'b0);
      queue_edge(0, 1, 8, 1'b0, 1'b1);

      for (int p = 0; p < 12; p++) begin
         write_node_count(counts[p]);
         set_idling(p % 4);
         queued = 0;
         if (p == 1) hold_requests++;
         if (p == 4) queued = queue_chain(DEF_MAX_NODES, 65535);
         queue_phase(counts[p], 128 - queued);
      end

      wait_idle();
      repeat (END_DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
